### src/vmrq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// vmrq_pkg
// Shared types, constants and the message check for the message ring queue.
// ============================================================================
package vmrq_pkg;

    localparam int unsigned DefDepth = 64;
    localparam int unsigned WordW    = 64;
    localparam int unsigned NumWords = 4;
    localparam int unsigned MsgW     = NumWords * WordW;
    localparam int unsigned SizeW    = 7;
    localparam int unsigned BytesW   = 8;
    localparam int unsigned StatusW  = 2;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 8;

    localparam logic [BytesW-1:0] MaxBytes = 8'd8;
    localparam logic [BytesW-1:0] ResetBytes = 8'd8;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic [CfgIdxW-1:0] REG_QUEUE_SIZE  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_TYPE_SET    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_WORD0_BYTES = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_WORD1_BYTES = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_WORD2_BYTES = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_WORD3_BYTES = 3'd5;

    typedef enum logic [StatusW-1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_EMPTY  = 2'd2
    } t_status;

    typedef logic [NumWords-1:0][WordW-1:0] t_msg;

    typedef struct packed {
        logic [SizeW-1:0]                   queue_size;
        logic                               type_set;
        logic [NumWords-1:0][BytesW-1:0]    word_bytes;
    } t_cfg;

    typedef struct packed {
        logic  op;
        logic  msg_ok;
        t_msg  words;
    } t_cmd;

    // A message passes when type_set is set and each word's byte size is at most
    // eight with no bit at or above eight times that size set.
    function automatic logic msg_valid(t_msg w, t_cfg cfg);
        logic ok;
        ok = cfg.type_set;
        for (int i = 0; i < NumWords; i++) begin
            if (cfg.word_bytes[i] > MaxBytes) begin
                ok = 1'b0;
            end else if (cfg.word_bytes[i] < MaxBytes) begin
                if ((w[i] >> {cfg.word_bytes[i][2:0], 3'b000}) != '0) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

### src/vmrq_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// vmrq_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module vmrq_ram #(
    parameter int unsigned WIDTH = vmrq_pkg::MsgW,
    parameter int unsigned DEPTH = vmrq_pkg::DefDepth
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/vmrq_front.sv
`timescale 1ns / 1ps
// ============================================================================
// vmrq_front
// Accepts beats, checks send messages and holds them in a two-entry queue.
// ============================================================================
module vmrq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_op,
    input  vmrq_pkg::t_msg    i_words,
    input  vmrq_pkg::t_cfg    i_cfg,
    output logic              o_full,
    output logic              o_cmd_valid,
    output vmrq_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);

    vmrq_pkg::t_cmd r_entry [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           push_ok;
    logic           pop_ok;
    vmrq_pkg::t_cmd new_cmd;

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_entry[r_rd_ptr];

    // The user must keep configuration stable while items are in flight (the block does
    // not enforce it), so sends are checked here once and the verdict travels with the beat.
    always_comb begin
        new_cmd.op     = i_op;
        new_cmd.msg_ok = vmrq_pkg::msg_valid(i_words, i_cfg);
        new_cmd.words  = i_words;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_entry[r_wr_ptr] <= new_cmd;
        end
    end

endmodule

### src/vmrq_back.sv
`timescale 1ns / 1ps
// ============================================================================
// vmrq_back
// Executes queued sends and receives against the slot RAM and the ring
// positions, and holds one result beat for the consumer.
// ============================================================================
module vmrq_back #(
    parameter int unsigned DEPTH = vmrq_pkg::DefDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vmrq_pkg::t_cfg                i_cfg,
    input  logic                          i_cfg_clear,
    input  logic                          i_cmd_valid,
    input  vmrq_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_ram_we,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_ram_waddr,
    output vmrq_pkg::t_msg                o_ram_wdata,
    output logic                          o_ram_re,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_ram_raddr,
    input  vmrq_pkg::t_msg                i_ram_rdata,
    output logic                          o_res_valid,
    input  logic                          i_res_pop,
    output logic [vmrq_pkg::StatusW-1:0]  o_status,
    output vmrq_pkg::t_msg                o_words
);

    localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW0 = $clog2(DEPTH + 1);
    localparam int unsigned CW  = (CW0 > vmrq_pkg::SizeW) ? CW0 : vmrq_pkg::SizeW;

    typedef enum logic {
        S_IDLE,
        S_CHECK
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_read_pos;
    logic [CW-1:0]     r_write_pos;
    logic [CW-1:0]     r_fill;
    logic              r_res_valid;
    vmrq_pkg::t_status r_status;
    vmrq_pkg::t_msg    r_words;

    logic [CW-1:0]     size_ext;
    logic [CW-1:0]     active;
    logic              send_ok;
    logic              head_ok;
    logic [CW-1:0]     write_inc;
    logic [CW-1:0]     read_inc;
    logic [CW-1:0]     n_write_pos;
    logic [CW-1:0]     n_read_pos;

    // A queue size beyond the slot count behaves as the slot count.
    assign size_ext = CW'(i_cfg.queue_size);
    assign active   = (size_ext > CW'(DEPTH)) ? CW'(DEPTH) : size_ext;

    assign send_ok = (active != '0) && (r_fill < active) && i_cmd.msg_ok;
    assign head_ok = vmrq_pkg::msg_valid(i_ram_rdata, i_cfg);

    assign write_inc   = r_write_pos + CW'(1);
    assign read_inc    = r_read_pos + CW'(1);
    assign n_write_pos = (write_inc >= active) ? '0 : write_inc;
    assign n_read_pos  = (read_inc >= active) ? '0 : read_inc;

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid && !r_res_valid;
    assign o_ram_we    = o_cmd_pop && (i_cmd.op == vmrq_pkg::OP_SEND) && send_ok;
    assign o_ram_waddr = r_write_pos[AW-1:0];
    assign o_ram_wdata = i_cmd.words;
    assign o_ram_re    = o_cmd_pop && (i_cmd.op == vmrq_pkg::OP_RECV) &&
                         (active != '0) && (r_fill != '0);
    assign o_ram_raddr = r_read_pos[AW-1:0];

    assign o_res_valid = r_res_valid;
    assign o_status    = vmrq_pkg::StatusW'(r_status);
    assign o_words     = r_words;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_read_pos  <= '0;
            r_write_pos <= '0;
            r_fill      <= '0;
            r_res_valid <= 1'b0;
            r_status    <= vmrq_pkg::ST_OK;
            r_words     <= '0;
        end else begin
            if (i_res_pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.op == vmrq_pkg::OP_SEND) begin
                            r_res_valid <= 1'b1;
                            r_words     <= '0;
                            if (send_ok) begin
                                r_status    <= vmrq_pkg::ST_OK;
                                r_write_pos <= n_write_pos;
                                r_fill      <= r_fill + CW'(1);
                            end else begin
                                r_status <= vmrq_pkg::ST_REJECT;
                            end
                        end else if (active == '0) begin
                            r_res_valid <= 1'b1;
                            r_words     <= '0;
                            r_status    <= vmrq_pkg::ST_REJECT;
                        end else if (r_fill == '0) begin
                            r_res_valid <= 1'b1;
                            r_words     <= '0;
                            r_status    <= vmrq_pkg::ST_EMPTY;
                        end else begin
                            // The head read was issued this cycle.
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_state     <= S_IDLE;
                    r_res_valid <= 1'b1;
                    if (head_ok) begin
                        r_status   <= vmrq_pkg::ST_OK;
                        r_words    <= i_ram_rdata;
                        r_read_pos <= n_read_pos;
                        r_fill     <= r_fill - CW'(1);
                    end else begin
                        // A failing head stays where it is.
                        r_status <= vmrq_pkg::ST_REJECT;
                        r_words  <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_clear) begin
                r_read_pos  <= '0;
                r_write_pos <= '0;
                r_fill      <= '0;
            end
        end
    end

endmodule

### src/validated_message_ring_queue_top.sv
`timescale 1ns / 1ps
// A send result reaches the result ports through the front queue entry and the
// result register; a receive result also passes the registered slot RAM read
// and the check state. Items go one at a time through a single result register;
// no command is taken during the check or while a result waits to be popped.
// Reset is synchronous and active low and restores positions, fill count and
// configuration; slot RAM contents are not cleared.
// ============================================================================
// validated_message_ring_queue_top
// Ring queue of four-word messages with per-word size validation.
// ============================================================================
module validated_message_ring_queue_top #(
    parameter int unsigned DEPTH = vmrq_pkg::DefDepth
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    output logic                           empty,
    input  logic                           pop,
    input  logic                           i_op,
    input  logic [vmrq_pkg::WordW-1:0]     i_in_word0,
    input  logic [vmrq_pkg::WordW-1:0]     i_in_word1,
    input  logic [vmrq_pkg::WordW-1:0]     i_in_word2,
    input  logic [vmrq_pkg::WordW-1:0]     i_in_word3,
    output logic [vmrq_pkg::StatusW-1:0]   o_status,
    output logic [vmrq_pkg::WordW-1:0]     o_out_word0,
    output logic [vmrq_pkg::WordW-1:0]     o_out_word1,
    output logic [vmrq_pkg::WordW-1:0]     o_out_word2,
    output logic [vmrq_pkg::WordW-1:0]     o_out_word3,
    input  logic                           i_cfg_we,
    input  logic [vmrq_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [vmrq_pkg::CfgDataW-1:0]  i_cfg_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    vmrq_pkg::t_cfg  r_cfg;
    logic            cfg_clear;
    vmrq_pkg::t_msg  in_words;
    vmrq_pkg::t_msg  out_words;
    logic            cmd_valid;
    vmrq_pkg::t_cmd  cmd;
    logic            cmd_pop;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    vmrq_pkg::t_msg  ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    vmrq_pkg::t_msg  ram_rdata;
    logic            res_valid;

    assign in_words[0] = i_in_word0;
    assign in_words[1] = i_in_word1;
    assign in_words[2] = i_in_word2;
    assign in_words[3] = i_in_word3;

    assign o_out_word0 = out_words[0];
    assign o_out_word1 = out_words[1];
    assign o_out_word2 = out_words[2];
    assign o_out_word3 = out_words[3];

    assign empty = !res_valid;

    // Any write to a defined register also empties the ring.
    assign cfg_clear = i_cfg_we && (i_cfg_idx <= vmrq_pkg::REG_WORD3_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.queue_size <= '0;
            r_cfg.type_set   <= 1'b0;
            r_cfg.word_bytes <= {vmrq_pkg::NumWords{vmrq_pkg::ResetBytes}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vmrq_pkg::REG_QUEUE_SIZE: begin
                    r_cfg.queue_size <= i_cfg_data[vmrq_pkg::SizeW-1:0];
                end
                vmrq_pkg::REG_TYPE_SET: begin
                    r_cfg.type_set <= i_cfg_data[0];
                end
                vmrq_pkg::REG_WORD0_BYTES: begin
                    r_cfg.word_bytes[0] <= i_cfg_data;
                end
                vmrq_pkg::REG_WORD1_BYTES: begin
                    r_cfg.word_bytes[1] <= i_cfg_data;
                end
                vmrq_pkg::REG_WORD2_BYTES: begin
                    r_cfg.word_bytes[2] <= i_cfg_data;
                end
                vmrq_pkg::REG_WORD3_BYTES: begin
                    r_cfg.word_bytes[3] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    vmrq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_op        (i_op),
        .i_words     (in_words),
        .i_cfg       (r_cfg),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    vmrq_ram #(
        .WIDTH (vmrq_pkg::MsgW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    vmrq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_clear (cfg_clear),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_res_valid (res_valid),
        .i_res_pop   (pop),
        .o_status    (o_status),
        .o_words     (out_words)
    );

endmodule
